### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define PRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, held off during reset
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

### hw/rtl/prs_pkg.sv
package prs_pkg;

    // Port widths fixed by the request and result fields
    localparam int NUMBER_BITS  = 64;
    localparam int ROUNDS_BITS  = 4;

    // Default operand width of the search
    localparam int NUMBER_WIDTH_DEF = 64;

    // Decimal base and round count ceiling
    localparam int DIGIT_BASE = 10;
    localparam int ROUNDS_MAX = 15;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] number;
        logic                   restart;
    } t_in_req;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] record_number;
        logic [ROUNDS_BITS-1:0] record_rounds;
    } t_out_req;

endpackage

### hw/rtl/prs_stream_if.sv
interface prs_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/persistence_record_search.sv
// One request at a time: each request runs through the double-dabble digit converter
//   and the serial digit multiplier (one digit per cycle) before the next is taken.
// A finished record waits in the output register while the next request is taken.
// Reset (synchronous, active low) clears the sequencer, the best round count and the result valid.
`include "assert_macros.svh"

module persistence_record_search #(
    parameter int NUMBER_WIDTH = prs_pkg::NUMBER_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prs_stream_if.sink   i_req,
    prs_stream_if.source o_res
);
    import prs_pkg::*;

    localparam int W   = NUMBER_WIDTH;
    // Decimal digits of 2^W - 1 (1233 / 4096 approximates log10 2)
    localparam int D   = ((W * 1233) >> 12) + 1;
    localparam int BW  = 4 * D;
    localparam int CW  = (W > 1) ? $clog2(W) : 1;
    localparam int MW  = W + 4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_CONV  = 5'b00100,
        S_MULT  = 5'b01000,
        S_JUDGE = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [ROUNDS_BITS-1:0] r_best, n_best;
    logic [ROUNDS_BITS-1:0] r_rounds, n_rounds;
    logic                   r_out_valid, n_out_valid;
    logic [W-1:0]           r_num, n_num;
    logic [W-1:0]           r_val, n_val;
    logic [W-1:0]           r_prod, n_prod;
    logic [BW-1:0]          r_bcd, n_bcd;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [NUMBER_BITS-1:0] r_out_number, n_out_number;
    logic [ROUNDS_BITS-1:0] r_out_rounds, n_out_rounds;

    logic [BW-1:0]          w_bcd_adj;
    logic [MW-1:0]          w_mul;
    logic [BW-1:0]          w_bcd_next;
    logic                   w_in_fire;
    logic                   w_out_fire;
    logic                   w_record;

    assign w_in_fire  = i_req.valid && i_req.ready;
    assign w_out_fire = o_res.valid && o_res.ready;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int k = 0; k < D; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                w_bcd_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                w_bcd_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    // Digit multiplier: running product times lowest digit
    assign w_mul      = MW'(r_prod) * MW'(r_bcd[3:0]);
    assign w_bcd_next = r_bcd >> 4;
    assign w_record   = r_rounds > r_best;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_best       = r_best;
        n_rounds     = r_rounds;
        n_out_valid  = r_out_valid;
        n_num        = r_num;
        n_val        = r_val;
        n_prod       = r_prod;
        n_bcd        = r_bcd;
        n_cnt        = r_cnt;
        n_out_number = r_out_number;
        n_out_rounds = r_out_rounds;

        // Drop the result once taken
        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_num    = i_req.data.number[W-1:0];
                    n_val    = i_req.data.number[W-1:0];
                    n_rounds = '0;
                    if (i_req.data.restart) begin
                        n_best = '0;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_val >= W'(DIGIT_BASE)) begin
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end else begin
                    n_state = S_JUDGE;
                end
            end
            S_CONV: begin
                // Shift one binary bit into the decimal register
                n_bcd = {w_bcd_adj[BW-2:0], r_val[W-1]};
                n_val = r_val << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_prod  = W'(1);
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                // Multiply in one digit, stop after the leading digit
                n_prod = w_mul[W-1:0];
                n_bcd  = w_bcd_next;
                if (w_bcd_next == '0) begin
                    n_val = w_mul[W-1:0];
                    if (r_rounds != ROUNDS_BITS'(ROUNDS_MAX)) begin
                        n_rounds = r_rounds + 1'b1;
                    end
                    n_state = S_CHECK;
                end
            end
            S_JUDGE: begin
                if (!w_record) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || o_res.ready) begin
                    // Load the record into the output register
                    n_best       = r_rounds;
                    n_out_valid  = 1'b1;
                    n_out_number = NUMBER_BITS'(r_num);
                    n_out_rounds = r_rounds;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rounds     <= n_rounds;
        r_num        <= n_num;
        r_val        <= n_val;
        r_prod       <= n_prod;
        r_bcd        <= n_bcd;
        r_cnt        <= n_cnt;
        r_out_number <= n_out_number;
        r_out_rounds <= n_out_rounds;
    end

    assign i_req.ready              = (r_state == S_IDLE);
    assign o_res.valid              = r_out_valid;
    assign o_res.data.record_number = r_out_number;
    assign o_res.data.record_rounds = r_out_rounds;

    // A new record always matches the best count and is never zero
    `PRS_ASSERT_SAME(a_rec_best, i_clk, i_rst_n, $rose(r_out_valid), (r_out_rounds == r_best) && (r_best != '0))
    // An accepted request always starts with the single-digit check
    `PRS_ASSERT_NEXT(a_accept_check, i_clk, i_rst_n, w_in_fire, r_state == S_CHECK)
    // The conversion always leaves towards the multiplier on the last bit
    `PRS_ASSERT_NEXT(a_conv_end, i_clk, i_rst_n, (r_state == S_CONV) && (r_cnt == CW'(W - 1)), r_state == S_MULT)
    // A waiting result is never overwritten before it is taken
    `PRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(r_out_number))

endmodule
